// ----- src/wts_pkg.sv -----
`default_nettype none

package wts_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;

  // Exact width of a dot-product sum before the fraction is dropped
  localparam int unsigned SUM_W = 66;

  // Quotient bits produced by the divider, one per stage
  localparam int unsigned DIV_STEPS = 32;

  // Divider pipeline depth: operand stage, range check, steps, clamp
  localparam int unsigned DIV_LAT = DIV_STEPS + 3;

  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned MAT_REGS = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW0_XY = 4'd0,
    REG_ROW0_ZT = 4'd1,
    REG_ROW1_XY = 4'd2,
    REG_ROW1_ZT = 4'd3,
    REG_ROW3_XY = 4'd4,
    REG_ROW3_ZT = 4'd5,
    REG_SCREEN_W = 4'd6,
    REG_SCREEN_H = 4'd7
  } reg_idx_e;

  localparam logic [15:0] SCREEN_W_RST = 16'd1920;
  localparam logic [15:0] SCREEN_H_RST = 16'd1080;

endpackage

`default_nettype wire

// ----- src/wts_div.sv -----
`default_nettype none

// Signed fixed-point divide, truncated toward zero, clamped to 32 bits.
// One quotient bit per stage.
module wts_div #(
  parameter int unsigned FRAC_BITS = wts_pkg::FRAC_BITS_DEF,
  parameter int unsigned DW = wts_pkg::SUM_W - wts_pkg::FRAC_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 en_i,
  input  wire logic signed [DW-1:0] num_i,
  input  wire logic signed [DW-1:0] den_i,
  output logic signed [31:0]        quo_o,
  output logic                      sat_o
);

  localparam int unsigned N = wts_pkg::DIV_STEPS;

  // Operand stage
  logic [DW-1:0] an_q, bd_q;
  logic          neg_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      an_q  <= num_i[DW-1] ? DW'(-num_i) : DW'(num_i);
      bd_q  <= den_i[DW-1] ? DW'(-den_i) : DW'(den_i);
      neg_q <= num_i[DW-1] ^ den_i[DW-1];
    end
  end

  // Step registers; index 0 is loaded by the range check stage
  logic [DW-1:0] r_q   [0:N];
  logic [DW-1:0] b_q   [0:N];
  logic [31:0]   lo_q  [0:N];
  logic [31:0]   q_q   [0:N];
  logic          neg_s_q [0:N];
  logic          ovf_q [0:N];

  logic [DW-1:0] r0;
  assign r0 = an_q >> (32 - FRAC_BITS);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]     <= r0;
      b_q[0]     <= bd_q;
      lo_q[0]    <= {an_q[31-FRAC_BITS:0], {FRAC_BITS{1'b0}}};
      q_q[0]     <= '0;
      neg_s_q[0] <= neg_q;
      // Quotient would need more than 32 integer+fraction bits
      ovf_q[0]   <= (r0 >= bd_q);
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    logic [DW:0] rs;
    logic        ge;
    logic [DW:0] rn;

    always_comb begin
      rs = {r_q[i], lo_q[i][31]};
      ge = (rs >= {1'b0, b_q[i]});
      rn = ge ? (rs - {1'b0, b_q[i]}) : rs;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[i+1]     <= rn[DW-1:0];
        b_q[i+1]     <= b_q[i];
        lo_q[i+1]    <= {lo_q[i][30:0], 1'b0};
        q_q[i+1]     <= {q_q[i][30:0], ge};
        neg_s_q[i+1] <= neg_s_q[i];
        ovf_q[i+1]   <= ovf_q[i];
      end
    end
  end

  // Clamp the magnitude, then restore the sign
  logic [31:0] lim, mag;
  logic        sat;

  always_comb begin
    lim = neg_s_q[N] ? 32'h8000_0000 : 32'h7fff_ffff;
    sat = ovf_q[N] || (q_q[N] > lim);
    mag = sat ? lim : q_q[N];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quo_o <= neg_s_q[N] ? $signed(-mag) : $signed(mag);
      sat_o <= sat;
    end
  end

endmodule

`default_nettype wire

// ----- src/world_to_screen_projection.sv -----
`default_nettype none

// Channel | Direction | Handshake               | Payload
// --------+-----------+-------------------------+------------------------------------
// in      | input     | in_valid_i / in_stall_o | world_x_i, world_y_i, world_z_i
// out     | output    | out_valid_o / out_stall_i | screen_x_o, screen_y_o, clip_depth_o,
//         |           |                         | depth_zero_o, saturated_o
// cfg     | input     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// One item enters per cycle unless the output stalls; the stages in order are products,
// dot sums, the 35-stage divider (one quotient bit per step stage), viewport
// multiply, viewport sums, clamp into the output register.
// The whole pipeline advances as one; it halts only while a finished item
// sits in the output register and the receiver stalls it.
// Reset clears valid bits and sets the matrix to zero, the viewport to
// 1920 x 1080. Configuration is always ready and takes effect at once.
module world_to_screen_projection #(
  parameter int unsigned FRAC_BITS = wts_pkg::FRAC_BITS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic signed [31:0]              world_x_i,
  input  wire logic signed [31:0]              world_y_i,
  input  wire logic signed [31:0]              world_z_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic signed [31:0]                   screen_x_o,
  output logic signed [31:0]                   screen_y_o,
  output logic signed [31:0]                   clip_depth_o,
  output logic                                 depth_zero_o,
  output logic                                 saturated_o,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [wts_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [wts_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int unsigned SUM_W = wts_pkg::SUM_W;
  localparam int unsigned DW    = SUM_W - FRAC_BITS;   // dot product width
  localparam int unsigned LAT   = wts_pkg::DIV_LAT;
  localparam int unsigned VW    = 50;                  // viewport sum width

  // ------------------------------------------------------------------
  // Configuration registers
  // ------------------------------------------------------------------
  logic [63:0] mat_q [0:wts_pkg::MAT_REGS-1];
  logic [15:0] width_q, height_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(wts_pkg::MAT_REGS); i++) mat_q[i] <= '0;
      width_q  <= wts_pkg::SCREEN_W_RST;
      height_q <= wts_pkg::SCREEN_H_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (wts_pkg::reg_idx_e'(cfg_index_i))
        wts_pkg::REG_ROW0_XY: mat_q[0] <= cfg_data_i;
        wts_pkg::REG_ROW0_ZT: mat_q[1] <= cfg_data_i;
        wts_pkg::REG_ROW1_XY: mat_q[2] <= cfg_data_i;
        wts_pkg::REG_ROW1_ZT: mat_q[3] <= cfg_data_i;
        wts_pkg::REG_ROW3_XY: mat_q[4] <= cfg_data_i;
        wts_pkg::REG_ROW3_ZT: mat_q[5] <= cfg_data_i;
        wts_pkg::REG_SCREEN_W: width_q <= cfg_data_i[15:0];
        wts_pkg::REG_SCREEN_H: height_q <= cfg_data_i[15:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // ------------------------------------------------------------------
  // Pipeline control: every stage moves together
  // ------------------------------------------------------------------
  logic adv;
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  // ------------------------------------------------------------------
  // Stage 1: nine products, row r uses matrix registers 2r and 2r+1
  // ------------------------------------------------------------------
  logic signed [63:0] prod_q [0:2][0:2];
  logic               v1_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        prod_q[r][0] <= $signed(mat_q[2*r][31:0])    * world_x_i;
        prod_q[r][1] <= $signed(mat_q[2*r][63:32])   * world_y_i;
        prod_q[r][2] <= $signed(mat_q[2*r+1][31:0])  * world_z_i;
      end
    end
  end

  // ------------------------------------------------------------------
  // Stage 2: exact sums plus the translation column, floored
  // ------------------------------------------------------------------
  logic signed [SUM_W-1:0] sum [0:2];
  logic signed [DW-1:0]    dot_q [0:2];
  logic                    v2_q;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum[r] = SUM_W'(prod_q[r][0]) + SUM_W'(prod_q[r][1]) + SUM_W'(prod_q[r][2])
             + (SUM_W'($signed(mat_q[2*r+1][63:32])) <<< FRAC_BITS);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) dot_q[r] <= sum[r][SUM_W-1:FRAC_BITS];
    end
  end

  // ------------------------------------------------------------------
  // Divider: nx = cx / w, ny = cy / w
  // ------------------------------------------------------------------
  logic signed [31:0] nx, ny;
  logic               nx_sat, ny_sat;

  wts_div #(.FRAC_BITS(FRAC_BITS), .DW(DW)) u_div_x (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (dot_q[0]),
    .den_i (dot_q[2]),
    .quo_o (nx),
    .sat_o (nx_sat)
  );

  wts_div #(.FRAC_BITS(FRAC_BITS), .DW(DW)) u_div_y (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (dot_q[1]),
    .den_i (dot_q[2]),
    .quo_o (ny),
    .sat_o (ny_sat)
  );

  // Carry w and valid alongside the divider
  logic signed [DW-1:0] dw_q [0:LAT-1];
  logic                 dv_q [0:LAT-1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dw_q[0] <= dot_q[2];
      for (int i = 1; i < int'(LAT); i++) dw_q[i] <= dw_q[i-1];
    end
  end

  // ------------------------------------------------------------------
  // Viewport stage A: scale by width and height, clamp w
  // ------------------------------------------------------------------
  logic signed [48:0] px_q, py_q;
  logic signed [31:0] depth_a_q;
  logic               zero_a_q, sat_a_q, va_q;
  logic               w_over, w_under;

  always_comb begin
    w_over  = !dw_q[LAT-1][DW-1] && (|dw_q[LAT-1][DW-2:31]);
    w_under =  dw_q[LAT-1][DW-1] && !(&dw_q[LAT-1][DW-2:31]);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      px_q      <= nx * $signed({1'b0, width_q});
      py_q      <= ny * $signed({1'b0, height_q});
      zero_a_q  <= (dw_q[LAT-1] == '0);
      depth_a_q <= w_over ? 32'sh7fff_ffff :
                   w_under ? 32'sh8000_0000 : dw_q[LAT-1][31:0];
      sat_a_q   <= nx_sat || ny_sat || w_over || w_under;
    end
  end

  // ------------------------------------------------------------------
  // Viewport stage B: center, add the half-pixel offset
  // ------------------------------------------------------------------
  logic signed [VW-1:0] half, wh, hh;
  logic signed [VW-1:0] sx_q, sy_q;
  logic signed [31:0]   depth_b_q;
  logic                 zero_b_q, sat_b_q, vb_q;

  always_comb begin
    half = VW'(1) <<< (FRAC_BITS - 1);
    wh   = $signed(VW'(width_q)) <<< (FRAC_BITS - 1);
    hh   = $signed(VW'(height_q)) <<< (FRAC_BITS - 1);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sx_q      <= wh + (VW'(px_q) >>> 1) + half;
      sy_q      <= hh - ((VW'(py_q) >>> 1) + half);
      depth_b_q <= depth_a_q;
      zero_b_q  <= zero_a_q;
      sat_b_q   <= sat_a_q;
    end
  end

  // ------------------------------------------------------------------
  // Output stage: clamp to 32 bits, force zeros on zero depth
  // ------------------------------------------------------------------
  logic sx_over, sx_under, sy_over, sy_under;

  always_comb begin
    sx_over  = !sx_q[VW-1] && (|sx_q[VW-2:31]);
    sx_under =  sx_q[VW-1] && !(&sx_q[VW-2:31]);
    sy_over  = !sy_q[VW-1] && (|sy_q[VW-2:31]);
    sy_under =  sy_q[VW-1] && !(&sy_q[VW-2:31]);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (zero_b_q) begin
        screen_x_o   <= '0;
        screen_y_o   <= '0;
        clip_depth_o <= '0;
        saturated_o  <= 1'b0;
      end else begin
        screen_x_o   <= sx_over ? 32'sh7fff_ffff :
                        sx_under ? 32'sh8000_0000 : sx_q[31:0];
        screen_y_o   <= sy_over ? 32'sh7fff_ffff :
                        sy_under ? 32'sh8000_0000 : sy_q[31:0];
        clip_depth_o <= depth_b_q;
        saturated_o  <= sat_b_q || sx_over || sx_under || sy_over || sy_under;
      end
      depth_zero_o <= zero_b_q;
    end
  end

  // ------------------------------------------------------------------
  // Valid bits
  // ------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      for (int i = 0; i < int'(LAT); i++) dv_q[i] <= 1'b0;
      va_q        <= 1'b0;
      vb_q        <= 1'b0;
      out_valid_o <= 1'b0;
    end else if (adv) begin
      v1_q        <= in_valid_i;
      v2_q        <= v1_q;
      dv_q[0]     <= v2_q;
      for (int i = 1; i < int'(LAT); i++) dv_q[i] <= dv_q[i-1];
      va_q        <= dv_q[LAT-1];
      vb_q        <= va_q;
      out_valid_o <= vb_q;
    end
  end

  // ------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------
  a_zero_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && depth_zero_o |->
      screen_x_o == 32'sd0 && screen_y_o == 32'sd0 && clip_depth_o == 32'sd0 &&
      !saturated_o)
    else $error("zero depth item carries nonzero results");

  a_stall_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input taken while output is held");

  a_hold_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vb_q && out_valid_o && out_stall_i |=> vb_q)
    else $error("pipeline item lost during stall");

endmodule

`default_nettype wire
